// ----- rtl/core/bsst_pkg.sv -----
// bsst_pkg: shared sizes, constants and types of the bounded set span tracker
// no dependencies; used by the interfaces, the cell and the top level
`timescale 1ns / 1ps

package bsst_pkg;

    localparam int CAPACITY = 64;
    localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int VAL_W    = 32;
    localparam int CFG_W    = 7;
    localparam int HC_W     = 7;
    localparam int LIM_W    = (CNT_W > CFG_W) ? CNT_W : CFG_W;

    localparam logic [CFG_W-1:0] CAP_RESET = CFG_W'(64);
    localparam logic [VAL_W-1:0] SIGN_FLIP = {1'b1, {(VAL_W-1){1'b0}}};
    localparam logic [VAL_W-1:0] GAP_ONES  = {VAL_W{1'b1}};

    // broadcast from the control to every cell
    typedef struct packed {
        logic [VAL_W-1:0] value;
        logic [CNT_W-1:0] cnt_old;
        logic [CNT_W-1:0] cnt_new;
        logic             shift_phase;
        logic             shift_en;
    } bcast_t;

    // link from one cell to its right neighbor
    typedef struct packed {
        logic [VAL_W-1:0] value;
        logic             gt;
        logic             ins;
    } link_t;

    // per cell contribution to the span results, zero when not selected
    typedef struct packed {
        logic [VAL_W-1:0] gap_lo;
        logic             lo_hit;
        logic [VAL_W-1:0] gap_hi;
        logic             hi_hit;
        logic [VAL_W-1:0] last_val;
    } span_t;

endpackage

// ----- rtl/core/bsst_if.sv -----
// bsst_if: valid/ready channel interfaces for items and results
// depends on bsst_pkg for field widths
`timescale 1ns / 1ps

interface bsst_item_if;
    logic                            valid;
    logic                            ready;
    logic signed [bsst_pkg::VAL_W-1:0] new_value;
    logic                            restart;

    modport source (output valid, output new_value, output restart, input ready);
    modport sink   (input valid, input new_value, input restart, output ready);
endinterface

interface bsst_result_if;
    logic                           valid;
    logic                           ready;
    logic                           accepted;
    logic [bsst_pkg::HC_W-1:0]      held_count;
    logic                           spans_valid;
    logic [bsst_pkg::VAL_W-1:0]     shortest_gap;
    logic [bsst_pkg::VAL_W-1:0]     widest_range;

    modport source (output valid, output accepted, output held_count, output spans_valid,
                    output shortest_gap, output widest_range, input ready);
    modport sink   (input valid, input accepted, input held_count, input spans_valid,
                    input shortest_gap, input widest_range, output ready);
endinterface

// ----- rtl/core/bsst_cell.sv -----
// bsst_cell: one compare-and-shift cell of the sorted chain
// depends on bsst_pkg
`timescale 1ns / 1ps

module bsst_cell (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic [bsst_pkg::IDX_W-1:0] idx,
    input  bsst_pkg::bcast_t           bcast,
    input  bsst_pkg::link_t            left,
    output bsst_pkg::link_t            right,
    output bsst_pkg::span_t            span
);
    import bsst_pkg::*;

    logic [VAL_W-1:0] value_reg, value_next;
    logic             ins_reg, ins_next;
    logic             occ_old, occ_new, gt_own, at_end, take_new;
    logic             is_last, lo_sel, hi_sel;
    logic [VAL_W-1:0] diff;
    logic [CNT_W-1:0] idx_ext;

    assign idx_ext = CNT_W'(idx);
    assign occ_old = idx_ext < bcast.cnt_old;
    assign occ_new = idx_ext < bcast.cnt_new;
    assign at_end  = idx_ext == bcast.cnt_old;
    // sign flip makes unsigned compare follow signed order
    assign gt_own  = occ_old && ((value_reg ^ SIGN_FLIP) > (bcast.value ^ SIGN_FLIP));
    assign take_new = (gt_own || at_end) && !left.gt;

    always_comb
    begin
        value_next = value_reg;
        ins_next   = ins_reg;
        if (bcast.shift_phase)
        begin
            ins_next = bcast.shift_en && take_new;
            if (bcast.shift_en)
            begin
                if (left.gt)
                    value_next = left.value;
                else if (take_new)
                    value_next = bcast.value;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ins_reg <= 1'b0;
        else
            ins_reg <= ins_next;
    end

    // gap to the left neighbor, read after the shift has settled
    assign diff    = value_reg - left.value;
    assign lo_sel  = ins_reg && (idx != '0);
    assign hi_sel  = left.ins && occ_new;
    assign is_last = idx_ext == (bcast.cnt_new - CNT_W'(1));

    assign right.value = value_reg;
    assign right.gt    = gt_own;
    assign right.ins   = ins_reg;

    assign span.gap_lo   = lo_sel ? diff : '0;
    assign span.lo_hit   = lo_sel;
    assign span.gap_hi   = hi_sel ? diff : '0;
    assign span.hi_hit   = hi_sel;
    assign span.last_val = is_last ? value_reg : '0;

endmodule

// ----- rtl/core/bounded_set_span_tracker.sv -----
// bounded_set_span_tracker: top level, control, cell chain and result register
// depends on bsst_pkg, bsst_if and bsst_cell
`timescale 1ns / 1ps

// The block keeps up to CAPACITY signed values in ascending order in a row of
// compare-and-shift cells. Each transaction on item_in may first empty the
// store (restart) and then inserts new_value after any equal values, unless
// the count has reached capacity_limit (values above CAPACITY act as
// CAPACITY). Every item yields one transaction on result_out with the accept
// flag, the count, and - once two or more values are held - the smallest gap
// between neighbors and the max-minus-min range, both as unsigned 32-bit
// numbers. An item passes the accept edge, a shift cycle in which every cell
// compares itself with the broadcast value and shifts right in one step, and
// a span cycle that gathers the gaps around the inserted value and the range
// from the end cells. A new item is taken once the span cycle is done, even
// while the previous result still waits in the output register; a stalled
// result_out holds the span cycle. capacity_limit is to be written by the user
// via cfg_we/cfg_wdata while the block is idle; the block does not enforce it.

module bounded_set_span_tracker (
    input  logic                       clk,
    input  logic                       rst_n,
    bsst_item_if.sink                  item_in,
    bsst_result_if.source              result_out,
    input  logic                       cfg_we,
    input  logic [bsst_pkg::CFG_W-1:0] cfg_wdata
);
    import bsst_pkg::*;

    // state codes
    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_SHIFT = 2'd1;
    localparam logic [1:0] ST_SPAN  = 2'd2;

    logic [1:0]       state_reg, state_next;
    logic [CFG_W-1:0] cap_reg;
    logic [VAL_W-1:0] value_reg;
    logic             restart_reg;
    logic [CNT_W-1:0] fill_reg, fill_next;
    logic [VAL_W-1:0] min_gap_reg, min_gap_next;
    logic             acc_reg, acc_next;

    // result register
    logic             out_valid_reg, out_valid_next;
    logic             out_acc_reg;
    logic [HC_W-1:0]  out_count_reg;
    logic             out_sv_reg;
    logic [VAL_W-1:0] out_gap_reg;
    logic [VAL_W-1:0] out_range_reg;

    logic             item_take, result_load;
    logic [LIM_W-1:0] limit;
    logic [CNT_W-1:0] cnt_old;
    logic             ins_ok;

    bcast_t           bcast;
    link_t            links [CAPACITY+1];
    span_t            spans [CAPACITY];
    logic [CAPACITY-1:0] ins_vec;

    // reduced span terms
    logic [VAL_W-1:0] gap_lo, gap_hi, last_val;
    logic             lo_hit, hi_hit;
    logic [VAL_W-1:0] min_a, min_b, range_val;
    logic             spans_ok;

    // handshakes
    assign item_in.ready = (state_reg == ST_IDLE);
    assign item_take     = item_in.valid && item_in.ready;
    assign result_load   = (state_reg == ST_SPAN) && (!out_valid_reg || result_out.ready);

    // effective limit, clamped to the chain length
    assign limit = (LIM_W'(cap_reg) > LIM_W'(CAPACITY)) ? LIM_W'(CAPACITY) : LIM_W'(cap_reg);
    // restart empties the store ahead of this value
    assign cnt_old = restart_reg ? '0 : fill_reg;
    assign ins_ok  = LIM_W'(cnt_old) < limit;

    assign bcast.value       = value_reg;
    assign bcast.cnt_old     = cnt_old;
    assign bcast.cnt_new     = fill_reg;
    assign bcast.shift_phase = (state_reg == ST_SHIFT);
    assign bcast.shift_en    = ins_ok;

    // the cell chain; the leftmost cell sees an empty neighbor
    assign links[0].value = '0;
    assign links[0].gt    = 1'b0;
    assign links[0].ins   = 1'b0;

    genvar gi;
    generate
        for (gi = 0; gi < CAPACITY; gi = gi + 1)
        begin : g_cell
            bsst_cell u_cell (
                .clk   (clk),
                .rst_n (rst_n),
                .idx   (IDX_W'(gi)),
                .bcast (bcast),
                .left  (links[gi]),
                .right (links[gi+1]),
                .span  (spans[gi])
            );
            assign ins_vec[gi] = links[gi+1].ins;
        end
    endgenerate

    // at most one cell is selected for each term, so an or gathers it
    always_comb
    begin
        gap_lo   = '0;
        gap_hi   = '0;
        last_val = '0;
        lo_hit   = 1'b0;
        hi_hit   = 1'b0;
        for (int i = 0; i < CAPACITY; i++)
        begin
            gap_lo   = gap_lo | spans[i].gap_lo;
            gap_hi   = gap_hi | spans[i].gap_hi;
            last_val = last_val | spans[i].last_val;
            lo_hit   = lo_hit | spans[i].lo_hit;
            hi_hit   = hi_hit | spans[i].hi_hit;
        end
    end

    // the new value can only narrow the gap it split
    assign min_a     = (lo_hit && gap_lo < min_gap_reg) ? gap_lo : min_gap_reg;
    assign min_b     = (hi_hit && gap_hi < min_a) ? gap_hi : min_a;
    assign range_val = last_val - links[1].value;
    assign spans_ok  = fill_reg >= CNT_W'(2);

    // control sequence
    always_comb
    begin
        state_next   = state_reg;
        fill_next    = fill_reg;
        min_gap_next = min_gap_reg;
        acc_next     = acc_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (item_take)
                    state_next = ST_SHIFT;
            end
            ST_SHIFT:
            begin
                acc_next   = ins_ok;
                fill_next  = cnt_old + CNT_W'(ins_ok);
                if (restart_reg)
                    min_gap_next = GAP_ONES;
                state_next = ST_SPAN;
            end
            ST_SPAN:
            begin
                if (result_load)
                begin
                    min_gap_next = min_b;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (result_load)
            out_valid_next = 1'b1;
        else if (out_valid_reg && result_out.ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            fill_reg      <= '0;
            min_gap_reg   <= GAP_ONES;
            acc_reg       <= 1'b0;
            cap_reg       <= CAP_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            fill_reg      <= fill_next;
            min_gap_reg   <= min_gap_next;
            acc_reg       <= acc_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
                cap_reg <= cfg_wdata;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (item_take)
        begin
            value_reg   <= item_in.new_value;
            restart_reg <= item_in.restart;
        end
        if (result_load)
        begin
            out_acc_reg   <= acc_reg;
            out_count_reg <= HC_W'(fill_reg);
            out_sv_reg    <= spans_ok;
            out_gap_reg   <= spans_ok ? min_b : '0;
            out_range_reg <= spans_ok ? range_val : '0;
        end
    end

    assign result_out.valid        = out_valid_reg;
    assign result_out.accepted     = out_acc_reg;
    assign result_out.held_count   = out_count_reg;
    assign result_out.spans_valid  = out_sv_reg;
    assign result_out.shortest_gap = out_gap_reg;
    assign result_out.widest_range = out_range_reg;

    // count never runs past the chain
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= CNT_W'(CAPACITY))
        else $error("fill count beyond chain length");

    // an accepted transaction is followed by the shift cycle
    a_take_shift: assert property (@(posedge clk) disable iff (!rst_n)
        item_take |=> state_reg == ST_SHIFT)
        else $error("no shift cycle after accepted transaction");

    // at most one cell takes the new value
    a_ins_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(ins_vec))
        else $error("more than one cell took the new value");

    // a rejected value marks no cell
    a_reject_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SPAN && !acc_reg) |-> ins_vec == '0)
        else $error("rejected value marked a cell");

endmodule

// ----- tb/bounded_set_span_tracker_test.sv -----
// bounded_set_span_tracker_test: self-checking bench for the sorted-set span tracker
// drives item transactions, predicts count, smallest gap and range per item, checks results
// depends on bsst_pkg, bsst_if and the rtl top level bounded_set_span_tracker
`timescale 1ns / 1ps

module bounded_set_span_tracker_test;

    import bsst_pkg::*;

    // no-transaction watchdog, well above the long receiver hold-off
    localparam int STALL_LIMIT = 3000;
    localparam int HOLD_OFF_CYCLES = 200;

    typedef struct packed {
        logic signed [VAL_W-1:0] new_value;
        logic                    restart;
    } set_item_t;

    typedef struct packed {
        logic             accepted;
        logic [HC_W-1:0]  held_count;
        logic             spans_valid;
        logic [VAL_W-1:0] shortest_gap;
        logic [VAL_W-1:0] widest_range;
    } span_report_t;

    logic             clk = 1'b0;
    logic             rst_n;
    logic             cfg_we;
    logic [CFG_W-1:0] cfg_wdata;

    bsst_item_if   item_ch();
    bsst_result_if result_ch();

    bounded_set_span_tracker i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_in    (item_ch),
        .result_out (result_ch),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata)
    );

    // stimulus waiting for the driver, and reports waiting for the block
    set_item_t    pending_items[$];
    span_report_t expected_reports[$];

    // shadow of the store: held values in ascending signed order
    logic signed [VAL_W-1:0] held_values[$];
    logic [VAL_W-1:0]        min_gap_shadow = GAP_ONES;
    logic [CFG_W-1:0]        limit_shadow = CAP_RESET;

    int failures = 0;
    int results_seen = 0;
    int run_left = 0;

    // idling state of both sides
    int send_gap = 0;
    int send_mode_left = 0;
    bit send_calm = 1'b0;
    int take_gap = 0;
    int take_mode_left = 0;
    bit take_calm = 1'b0;
    int hold_off_left = 0;

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // prediction: restart, bounded sorted insert, incremental minimum gap
    // ------------------------------------------------------------------
    function automatic span_report_t insert_and_measure(set_item_t it);
        span_report_t            rep;
        logic signed [VAL_W-1:0] v;
        logic [VAL_W-1:0]        d;
        int                      pos;
        int                      eff_limit;
        rep = '0;
        v = it.new_value;
        if (it.restart)
        begin
            held_values.delete();
            min_gap_shadow = GAP_ONES;
        end
        // a limit above the store size acts as the store size
        eff_limit = (int'(limit_shadow) > CAPACITY) ? CAPACITY : int'(limit_shadow);
        if (held_values.size() < eff_limit)
        begin
            // equal values go after their equals
            pos = 0;
            while (pos < held_values.size() && held_values[pos] <= v)
                pos++;
            // only the gaps next to the new value can lower the minimum
            if (pos > 0)
            begin
                d = v - held_values[pos-1];
                if (d < min_gap_shadow)
                    min_gap_shadow = d;
            end
            if (pos < held_values.size())
            begin
                d = held_values[pos] - v;
                if (d < min_gap_shadow)
                    min_gap_shadow = d;
            end
            held_values.insert(pos, v);
            rep.accepted = 1'b1;
        end
        rep.held_count = HC_W'(held_values.size());
        // fewer than two values: spans stay zero
        if (held_values.size() >= 2)
        begin
            rep.spans_valid  = 1'b1;
            rep.shortest_gap = min_gap_shadow;
            rep.widest_range = held_values[held_values.size()-1] - held_values[0];
        end
        return rep;
    endfunction

    // mostly back-to-back, some short gaps, a few long ones
    function automatic int next_gap(bit calm);
        int r;
        if (calm)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // value mix: full range, a narrow band for duplicates and tiny gaps,
    // the extremes, and clusters near zero and near the most negative value
    function automatic logic [VAL_W-1:0] pick_value();
        int r;
        r = $urandom_range(0, 99);
        if (r < 35)
            return $urandom();
        if (r < 65)
            return VAL_W'(int'($urandom_range(0, 40)) - 20);
        if (r < 75)
        begin
            case ($urandom_range(0, 5))
                0: return 32'h7FFF_FFFF;
                1: return 32'h8000_0000;
                2: return 32'h0000_0000;
                3: return 32'hFFFF_FFFF;
                4: return 32'h8000_0001;
                default: return 32'h7FFF_FFFE;
            endcase
        end
        return $urandom() & 32'h8000_00FF;
    endfunction

    task automatic push_item(logic [VAL_W-1:0] v, logic r);
        set_item_t it;
        it.new_value = v;
        it.restart   = r;
        pending_items.insert(pending_items.size(), it);
    endtask

    // runs of inserts that each open with a restart, with the odd stray restart
    task automatic queue_random(int n);
        logic r;
        int   k;
        for (int i = 0; i < n; i++)
        begin
            if (run_left == 0)
            begin
                r = 1'b1;
                k = $urandom_range(0, 99);
                if (k < 65)
                    run_left = $urandom_range(1, 12);
                else if (k < 88)
                    run_left = $urandom_range(13, 40);
                else
                    run_left = $urandom_range(55, 90);
            end
            else
            begin
                r = ($urandom_range(0, 49) == 0);
            end
            run_left--;
            push_item(pick_value(), r);
        end
    endtask

    // one restart followed by a long run, to drive the store into its limit
    task automatic queue_fill(int n);
        push_item(pick_value(), 1'b1);
        for (int i = 1; i < n; i++)
            push_item(pick_value(), 1'b0);
        run_left = 0;
    endtask

    // wait until every transaction is sent and every report has come back
    task automatic settle();
        while (pending_items.size() != 0 || item_ch.valid || expected_reports.size() != 0)
            @(posedge clk);
        repeat (3) @(posedge clk);
    endtask

    task automatic write_limit(logic [CFG_W-1:0] v);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        limit_shadow = v;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    // ------------------------------------------------------------------
    // driver: offers the head of the pending queue, holds it until taken
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            item_ch.valid     <= 1'b0;
            item_ch.new_value <= '0;
            item_ch.restart   <= 1'b0;
        end
        else
        begin
            if (item_ch.valid && item_ch.ready)
            begin
                expected_reports.insert(expected_reports.size(),
                                        insert_and_measure(pending_items.pop_front()));
                send_gap = next_gap(send_calm);
            end
            // switch between calm stretches and idling stretches now and then
            if (send_mode_left == 0)
            begin
                send_calm      = ($urandom_range(0, 2) == 0);
                send_mode_left = $urandom_range(40, 300);
            end
            else
            begin
                send_mode_left--;
            end
            // an offered transaction stays put until the block takes it
            if (!(item_ch.valid && !item_ch.ready))
            begin
                if (send_gap > 0)
                begin
                    send_gap--;
                    item_ch.valid <= 1'b0;
                end
                else if (pending_items.size() != 0)
                begin
                    item_ch.valid     <= 1'b1;
                    item_ch.new_value <= pending_items[0].new_value;
                    item_ch.restart   <= pending_items[0].restart;
                end
                else
                begin
                    item_ch.valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // monitor: compares each result transaction with the oldest report
    // ------------------------------------------------------------------
    task automatic check_report();
        span_report_t want;
        if (expected_reports.size() == 0)
        begin
            $error("result transaction with no report pending");
            failures++;
        end
        else
        begin
            want = expected_reports.pop_front();
            if (result_ch.accepted !== want.accepted)
            begin
                $error("accepted: expected %0d, got %0d", want.accepted, result_ch.accepted);
                failures++;
            end
            if (result_ch.held_count !== want.held_count)
            begin
                $error("held_count: expected %0d, got %0d", want.held_count,
                       result_ch.held_count);
                failures++;
            end
            if (result_ch.spans_valid !== want.spans_valid)
            begin
                $error("spans_valid: expected %0d, got %0d", want.spans_valid,
                       result_ch.spans_valid);
                failures++;
            end
            if (result_ch.shortest_gap !== want.shortest_gap)
            begin
                $error("shortest_gap: expected %h, got %h", want.shortest_gap,
                       result_ch.shortest_gap);
                failures++;
            end
            if (result_ch.widest_range !== want.widest_range)
            begin
                $error("widest_range: expected %h, got %h", want.widest_range,
                       result_ch.widest_range);
                failures++;
            end
        end
    endtask

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            result_ch.ready <= 1'b0;
        end
        else
        begin
            if (result_ch.valid && result_ch.ready)
            begin
                check_report();
                results_seen++;
                take_gap = next_gap(take_calm);
                // long hold-off while the driver keeps offering: block backs up
                if (results_seen == 300 || results_seen == 1200)
                    hold_off_left = HOLD_OFF_CYCLES;
            end
            if (take_mode_left == 0)
            begin
                take_calm      = ($urandom_range(0, 2) == 0);
                take_mode_left = $urandom_range(40, 300);
            end
            else
            begin
                take_mode_left--;
            end
            if (hold_off_left > 0)
            begin
                hold_off_left--;
                result_ch.ready <= 1'b0;
            end
            else if (take_gap > 0)
            begin
                take_gap--;
                result_ch.ready <= 1'b0;
            end
            else
            begin
                result_ch.ready <= 1'b1;
            end
        end
    end

    // watchdog: too many cycles without any transaction on either side
    initial
    begin
        int idle_run;
        idle_run = 0;
        while (idle_run < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((item_ch.valid && item_ch.ready) || (result_ch.valid && result_ch.ready))
                idle_run = 0;
            else
                idle_run++;
        end
        $display("Test completed with failures");
        $finish;
    end

    // ------------------------------------------------------------------
    // sequence: reset, directed items, then limit settings with random runs
    // ------------------------------------------------------------------
    initial
    begin
        rst_n             = 1'b0;
        cfg_we            = 1'b0;
        cfg_wdata         = '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        write_limit(CFG_W'(64));
        // extremes of the signed range, duplicates at both ends and in the middle
        push_item(32'h0000_0000, 1'b1);
        push_item(32'h7FFF_FFFF, 1'b0);
        push_item(32'h8000_0000, 1'b0);
        push_item(32'h0000_0000, 1'b0);
        push_item(32'hFFFF_FFFF, 1'b0);
        push_item(32'h0000_0001, 1'b0);
        push_item(32'h8000_0000, 1'b0);
        push_item(32'h7FFF_FFFF, 1'b0);
        // restart leaves one value, spans invalid; then an equal value gives gap zero
        push_item(32'h0000_0005, 1'b1);
        push_item(32'h0000_0005, 1'b0);
        push_item(32'hAAAA_AAAA, 1'b1);
        push_item(32'h5555_5555, 1'b0);
        // widest possible gap and range in one pair
        push_item(32'h8000_0000, 1'b1);
        push_item(32'h7FFF_FFFF, 1'b0);
        // inserts that split an existing gap
        push_item(32'd100, 1'b1);
        push_item(32'd200, 1'b0);
        push_item(32'd150, 1'b0);
        push_item(32'd175, 1'b0);
        push_item(32'd160, 1'b0);
        push_item(32'd99, 1'b0);
        push_item(32'd201, 1'b0);
        settle();

        // limit zero rejects everything, restart included
        write_limit(CFG_W'(0));
        queue_random(30);
        settle();

        write_limit(CFG_W'(1));
        queue_random(50);
        settle();

        write_limit(CFG_W'(2));
        queue_random(60);
        settle();

        // limit above the store size acts as the store size
        write_limit(CFG_W'(127));
        queue_fill(70);
        queue_random(400);
        settle();

        write_limit(CFG_W'(50));
        queue_fill(55);
        settle();

        // limit lowered below the count: rejections until the next restart
        write_limit(CFG_W'(3));
        run_left = 20;
        queue_random(120);
        settle();

        write_limit(CFG_W'(64));
        queue_fill(66);
        queue_random(500);
        settle();

        write_limit(CFG_W'(17));
        queue_random(200);
        settle();

        write_limit(CFG_W'($urandom_range(0, 127)));
        queue_random(250);
        settle();

        write_limit(CFG_W'(64));
        queue_random(80);
        settle();

        repeat (8) @(posedge clk);
        if (failures == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

// ----- files.f -----
rtl/core/bsst_pkg.sv
rtl/core/bsst_if.sv
rtl/core/bsst_cell.sv
rtl/core/bounded_set_span_tracker.sv
tb/bounded_set_span_tracker_test.sv
